@@ rtl/snell_refraction_vector_macros.svh @@
// assertion macros used by the checker file of the refraction block
// depends on: nothing; expects clk and rst in the scope of use
`ifndef SNELL_REFRACTION_VECTOR_MACROS_SVH
`define SNELL_REFRACTION_VECTOR_MACROS_SVH

// same-cycle implication, held off during reset
`define SRV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define SRV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/srv_pkg.sv @@
// shared types and constants of the vector refraction pipeline
// depends on: nothing
package srv_pkg;

  localparam int AXES   = 3;
  localparam int SQ_W   = 62;
  localparam int ROOT_W = SQ_W / 2;
  localparam int MAG_W  = 30;
  localparam int QW     = 15;
  localparam int NUM_W  = MAG_W + QW;

  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

  typedef logic [AXES-1:0][15:0] vec_t;

  typedef struct packed {
    logic [15:0]        a;
    logic signed [33:0] cosi;
    vec_t               inc;
    vec_t               nrm;
    logic               tir;
  } ray_t;

  typedef struct packed {
    logic [AXES-1:0][MAG_W-1:0] mag;
    logic [AXES-1:0]            neg;
    logic                       zero;
    logic                       tir;
  } unit_t;

  typedef struct packed {
    logic [AXES-1:0] neg;
    logic            zero;
    logic            tir;
  } sign_t;

endpackage

@@ rtl/srv_isqrt.sv @@
// pipelined integer square root, one root bit per register stage
// depends on: nothing; carries an opaque side word alongside each request
module srv_isqrt #(
  parameter int W  = 62,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [W-1:0]    value,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [W/2-1:0]  root,
  output logic [SW-1:0]   side_out
);

  localparam int N  = W / 2;
  localparam int RW = N + 2;

  logic          vld  [N];
  logic [RW-1:0] rem  [N];
  logic [N-1:0]  rt   [N];
  logic [W-1:0]  rest [N];
  logic [SW-1:0] side [N];

  for (genvar g = 0; g < N; g++) begin : g_step
    logic          p_vld;
    logic [RW-1:0] p_rem;
    logic [N-1:0]  p_rt;
    logic [W-1:0]  p_rest;
    logic [SW-1:0] p_side;
    logic [RW-1:0] sh;
    logic [RW-1:0] trial;
    logic          ge;

    if (g == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_rt   = '0;
      assign p_rest = value;
      assign p_side = side_in;
    end else begin : g_next
      assign p_vld  = vld[g-1];
      assign p_rem  = rem[g-1];
      assign p_rt   = rt[g-1];
      assign p_rest = rest[g-1];
      assign p_side = side[g-1];
    end

    assign sh    = {p_rem[RW-3:0], p_rest[W-1:W-2]};
    assign trial = {p_rt, 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= ge ? sh - trial : sh;
        rt[g]   <= {p_rt[N-2:0], ge};
        rest[g] <= {p_rest[W-3:0], 2'b00};
        side[g] <= p_side;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign root      = rt[N-1];
  assign side_out  = side[N-1];

endmodule

@@ rtl/srv_front.sv @@
// front stages: cosine of incidence, sin^2 test against one, radicand for cosT
// depends on: srv_pkg
module srv_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  srv_pkg::vec_t            inc,
  input  srv_pkg::vec_t            nrm,
  input  logic [15:0]              ior_from,
  input  logic [15:0]              ior_to,
  output logic                     out_valid,
  output logic [srv_pkg::SQ_W-1:0] diff,
  output srv_pkg::ray_t            ray
);

  import srv_pkg::*;

  // stage 1: component products
  logic               v1;
  logic signed [31:0] prod1 [AXES];
  logic [15:0]        a1, b1;
  vec_t               inc1, nrm1;

  // stage 2: cosine and index squares
  logic               v2;
  logic signed [33:0] cosi2;
  logic [31:0]        aa2, bb2;
  logic [15:0]        a2;
  vec_t               inc2, nrm2;

  // stage 3: cosine squared
  logic               v3;
  logic [63:0]        csq3;
  logic [31:0]        aa3, bb3;
  logic [15:0]        a3;
  logic signed [33:0] cosi3;
  vec_t               inc3, nrm3;

  // stage 4: both sides of the reflection test
  logic               v4;
  logic [60:0]        lhs4;
  logic [59:0]        rhs4;
  logic               bzero4;
  logic [15:0]        a4;
  logic signed [33:0] cosi4;
  vec_t               inc4, nrm4;

  // stage 5: radicand
  logic               v5;
  logic [SQ_W-1:0]    diff5;
  ray_t               ray5;

  logic signed [33:0] dot;
  logic [33:0]        cmag;
  logic [35:0]        sq;
  logic [28:0]        s;
  logic               tir;

  always_comb begin
    dot  = 34'(prod1[0]) + 34'(prod1[1]) + 34'(prod1[2]);
    cmag = cosi2[33] ? 34'(-cosi2) : 34'(cosi2);
    sq   = csq3[63:28];
    s    = (sq >= 36'(ONE_Q28)) ? 29'd0 : ONE_Q28 - sq[28:0];
    tir  = bzero4 || ({1'b0, rhs4} < lhs4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < AXES; j++) begin
        prod1[j] <= $signed(inc[j]) * $signed(nrm[j]);
      end
      a1   <= ior_from;
      b1   <= ior_to;
      inc1 <= inc;
      nrm1 <= nrm;

      cosi2 <= -dot;
      aa2   <= 32'(a1) * 32'(a1);
      bb2   <= 32'(b1) * 32'(b1);
      a2    <= a1;
      inc2  <= inc1;
      nrm2  <= nrm1;

      csq3  <= 64'(cmag[31:0]) * 64'(cmag[31:0]);
      aa3   <= aa2;
      bb3   <= bb2;
      a3    <= a2;
      cosi3 <= cosi2;
      inc3  <= inc2;
      nrm3  <= nrm2;

      lhs4   <= 61'(aa3) * 61'(s);
      rhs4   <= {bb3, 28'd0};
      bzero4 <= (bb3 == 32'd0);
      a4     <= a3;
      cosi4  <= cosi3;
      inc4   <= inc3;
      nrm4   <= nrm3;

      diff5     <= tir ? '0 : SQ_W'(rhs4) - SQ_W'(lhs4);
      ray5.a    <= a4;
      ray5.cosi <= cosi4;
      ray5.inc  <= inc4;
      ray5.nrm  <= nrm4;
      ray5.tir  <= tir;
    end
  end

  assign out_valid = v5;
  assign diff      = diff5;
  assign ray       = ray5;

endmodule

@@ rtl/srv_vec.sv @@
// refracted vector, common normalizing shift and sum of squares
// depends on: srv_pkg
module srv_vec (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [srv_pkg::ROOT_W-1:0] root,
  input  srv_pkg::ray_t              ray,
  output logic                       out_valid,
  output logic [srv_pkg::SQ_W-1:0]   sum,
  output srv_pkg::unit_t             unit
);

  import srv_pkg::*;

  typedef logic [AXES-1:0][63:0] wide_t;

  function automatic wide_t nstep(input wide_t w, input int sh);
    logic [63:0] any;
    wide_t       r;
    any = w[0] | w[1] | w[2];
    r   = w;
    if ((any >> (64 - sh)) == 64'd0) begin
      for (int j = 0; j < AXES; j++) begin
        r[j] = w[j] << sh;
      end
    end
    return r;
  endfunction

  logic [9:0] vld;

  // a*cosI, a*I
  logic signed [50:0]   acos1;
  logic [ROOT_W-1:0]    r1;
  logic signed [32:0]   ai1 [AXES];
  vec_t                 nrm1;
  logic                 tir1;
  // k truncated toward zero
  logic signed [37:0]   k2;
  logic signed [32:0]   ai2 [AXES];
  vec_t                 nrm2;
  logic                 tir2;
  // k*N
  logic signed [53:0]   kn3 [AXES];
  logic signed [32:0]   ai3 [AXES];
  logic                 tir3;
  // V
  logic signed [54:0]   v4 [AXES];
  logic                 tir4;
  // magnitudes
  wide_t                mag5;
  logic [AXES-1:0]      neg5;
  logic                 zero5, tir5;
  // normalizer
  wide_t                w6, w7, w8;
  logic [AXES-1:0]      neg6, neg7, neg8;
  logic                 zero6, zero7, zero8, tir6, tir7, tir8;
  // squares
  logic [59:0]          sq9 [AXES];
  unit_t                u9, u10;
  logic [SQ_W-1:0]      sum10;

  logic signed [51:0]   k28;
  logic signed [51:0]   kb;
  logic signed [54:0]   absv [AXES];
  logic                 allz;

  always_comb begin
    k28  = 52'(acos1) - 52'($signed({1'b0, r1, 14'd0}));
    kb   = k28 + (k28[51] ? 52'sd16383 : 52'sd0);
    allz = 1'b1;
    for (int j = 0; j < AXES; j++) begin
      absv[j] = v4[j][54] ? -v4[j] : v4[j];
      allz    = allz && (v4[j] == 55'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acos1 <= $signed({1'b0, ray.a}) * ray.cosi;
      r1    <= root;
      for (int j = 0; j < AXES; j++) begin
        ai1[j] <= $signed({1'b0, ray.a}) * $signed(ray.inc[j]);
      end
      nrm1 <= ray.nrm;
      tir1 <= ray.tir;

      k2   <= kb[51:14];
      ai2  <= ai1;
      nrm2 <= nrm1;
      tir2 <= tir1;

      for (int j = 0; j < AXES; j++) begin
        kn3[j] <= k2 * $signed(nrm2[j]);
      end
      ai3  <= ai2;
      tir3 <= tir2;

      for (int j = 0; j < AXES; j++) begin
        v4[j] <= 55'($signed({ai3[j], 14'd0})) + 55'(kn3[j]);
      end
      tir4 <= tir3;

      for (int j = 0; j < AXES; j++) begin
        mag5[j] <= 64'($unsigned(absv[j]));
        neg5[j] <= v4[j][54];
      end
      zero5 <= allz;
      tir5  <= tir4;

      w6    <= nstep(nstep(mag5, 32), 16);
      neg6  <= neg5;
      zero6 <= zero5;
      tir6  <= tir5;

      w7    <= nstep(nstep(w6, 8), 4);
      neg7  <= neg6;
      zero7 <= zero6;
      tir7  <= tir6;

      w8    <= nstep(nstep(w7, 2), 1);
      neg8  <= neg7;
      zero8 <= zero7;
      tir8  <= tir7;

      for (int j = 0; j < AXES; j++) begin
        sq9[j]    <= 60'(w8[j][63:34]) * 60'(w8[j][63:34]);
        u9.mag[j] <= w8[j][63:34];
      end
      u9.neg  <= neg8;
      u9.zero <= zero8;
      u9.tir  <= tir8;

      sum10 <= SQ_W'(sq9[0]) + SQ_W'(sq9[1]) + SQ_W'(sq9[2]);
      u10   <= u9;
    end
  end

  assign out_valid = vld[9];
  assign sum       = sum10;
  assign unit      = u10;

endmodule

@@ rtl/srv_div3.sv @@
// rounded division of the three magnitudes by the length, one quotient bit per stage
// depends on: srv_pkg
module srv_div3 (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [srv_pkg::ROOT_W-1:0]                len,
  input  srv_pkg::unit_t                            unit,
  output logic                                      out_valid,
  output logic [srv_pkg::AXES-1:0][srv_pkg::QW-1:0] quo,
  output srv_pkg::sign_t                            sgn
);

  import srv_pkg::*;

  localparam int RW = ROOT_W + 1;

  // numerator with half the divisor added for rounding
  logic                         v0;
  logic [AXES-1:0][NUM_W-1:0]   num0;
  logic [ROOT_W-1:0]            len0;
  sign_t                        sgn0;

  logic                         vld  [QW];
  logic [AXES-1:0][RW-1:0]      rem  [QW];
  logic [AXES-1:0][QW-1:0]      q    [QW];
  logic [AXES-1:0][QW-1:0]      rest [QW];
  logic [ROOT_W-1:0]            dlen [QW];
  sign_t                        dsgn [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < AXES; j++) begin
        num0[j] <= NUM_W'({unit.mag[j], 14'd0}) + NUM_W'(len[ROOT_W-1:1]);
      end
      len0      <= len;
      sgn0.neg  <= unit.neg;
      sgn0.zero <= unit.zero;
      sgn0.tir  <= unit.tir;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic                    p_vld;
    logic [AXES-1:0][RW-1:0] p_rem;
    logic [AXES-1:0][QW-1:0] p_q;
    logic [AXES-1:0][QW-1:0] p_rest;
    logic [ROOT_W-1:0]       p_len;
    sign_t                   p_sgn;
    logic [AXES-1:0][RW-1:0] sh;
    logic [AXES-1:0]         ge;

    if (g == 0) begin : g_first
      assign p_vld = v0;
      assign p_q   = '0;
      assign p_len = len0;
      assign p_sgn = sgn0;
      for (genvar j = 0; j < AXES; j++) begin : g_lane
        assign p_rem[j]  = RW'(num0[j][NUM_W-1:QW]);
        assign p_rest[j] = num0[j][QW-1:0];
      end
    end else begin : g_next
      assign p_vld  = vld[g-1];
      assign p_rem  = rem[g-1];
      assign p_q    = q[g-1];
      assign p_rest = rest[g-1];
      assign p_len  = dlen[g-1];
      assign p_sgn  = dsgn[g-1];
    end

    always_comb begin
      for (int j = 0; j < AXES; j++) begin
        sh[j] = {p_rem[j][RW-2:0], p_rest[j][QW-1]};
        ge[j] = (sh[j] >= RW'(p_len));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < AXES; j++) begin
          rem[g][j]  <= ge[j] ? sh[j] - RW'(p_len) : sh[j];
          q[g][j]    <= {p_q[j][QW-2:0], ge[j]};
          rest[g][j] <= {p_rest[j][QW-2:0], 1'b0};
        end
        dlen[g] <= p_len;
        dsgn[g] <= p_sgn;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = q[QW-1];
  assign sgn       = dsgn[QW-1];

endmodule

@@ rtl/snell_refraction_vector.sv @@
// Refracts a unit incident direction at a surface by Snell's law and returns the unit refracted
// direction in signed Q2.14, or a zero vector with total_internal set. One request enters per
// cycle while in_stall is low; most of the depth comes from the two square-root pipelines
// (31 stages each, one root bit per stage) and the divider that scales the vector to unit length
// with 15 quotient-bit stages. in_stall rises only while a finished result sits at the output with
// out_stall high, and the whole pipeline then holds. Depends on srv_pkg and the srv_* modules.
module snell_refraction_vector (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] incident_x,
  input  logic signed [15:0] incident_y,
  input  logic signed [15:0] incident_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [15:0]        ior_from,
  input  logic [15:0]        ior_to,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic               total_internal
);

  import srv_pkg::*;

  localparam int RAY_W  = $bits(ray_t);
  localparam int UNIT_W = $bits(unit_t);

  logic                       en;
  vec_t                       inc, nrm;

  logic                       f_valid;
  logic [SQ_W-1:0]            f_diff;
  ray_t                       f_ray;

  logic                       r_valid;
  logic [ROOT_W-1:0]          r_root;
  logic [RAY_W-1:0]           r_side;

  logic                       v_valid;
  logic [SQ_W-1:0]            v_sum;
  unit_t                      v_unit;

  logic                       l_valid;
  logic [ROOT_W-1:0]          l_len;
  logic [UNIT_W-1:0]          l_side;

  logic                       d_valid;
  logic [AXES-1:0][QW-1:0]    d_quo;
  sign_t                      d_sgn;

  logic [AXES-1:0][15:0]      res;
  logic [AXES-1:0][15:0]      res_q;
  logic                       tir_q;
  logic                       ovalid;

  assign en       = !(ovalid && out_stall);
  assign in_stall = ovalid && out_stall;
  assign inc      = {incident_z, incident_y, incident_x};
  assign nrm      = {normal_z, normal_y, normal_x};

  srv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .inc       (inc),
    .nrm       (nrm),
    .ior_from  (ior_from),
    .ior_to    (ior_to),
    .out_valid (f_valid),
    .diff      (f_diff),
    .ray       (f_ray)
  );

  srv_isqrt #(.W(SQ_W), .SW(RAY_W)) u_cos_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .value     (f_diff),
    .side_in   (f_ray),
    .out_valid (r_valid),
    .root      (r_root),
    .side_out  (r_side)
  );

  srv_vec u_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .root      (r_root),
    .ray       (ray_t'(r_side)),
    .out_valid (v_valid),
    .sum       (v_sum),
    .unit      (v_unit)
  );

  srv_isqrt #(.W(SQ_W), .SW(UNIT_W)) u_length (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_valid),
    .value     (v_sum),
    .side_in   (v_unit),
    .out_valid (l_valid),
    .root      (l_len),
    .side_out  (l_side)
  );

  srv_div3 u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (l_valid),
    .len       (l_len),
    .unit      (unit_t'(l_side)),
    .out_valid (d_valid),
    .quo       (d_quo),
    .sgn       (d_sgn)
  );

  always_comb begin
    for (int j = 0; j < AXES; j++) begin
      if (d_sgn.tir || d_sgn.zero) begin
        res[j] = '0;
      end else if (d_sgn.neg[j]) begin
        res[j] = -(16'(d_quo[j]));
      end else begin
        res[j] = 16'(d_quo[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q <= res;
      tir_q <= d_sgn.tir;
    end
  end

  assign out_valid      = ovalid;
  assign out_x          = res_q[0];
  assign out_y          = res_q[1];
  assign out_z          = res_q[2];
  assign total_internal = tir_q;

endmodule

@@ rtl/srv_checker.sv @@
// port-level checks of the refraction block, bound to the top level
// depends on: snell_refraction_vector_macros.svh
`include "snell_refraction_vector_macros.svh"

module srv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [15:0] incident_x,
  input logic signed [15:0] incident_y,
  input logic signed [15:0] incident_z,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic [15:0]        ior_from,
  input logic [15:0]        ior_to,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z,
  input logic               total_internal
);

  // total reflection carries no direction
  `SRV_ASSERT_NOW(a_tir_zero, out_valid && total_internal, out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0, "total reflection with nonzero vector")

  // input side holds only behind a held result
  `SRV_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

  // unit vector components never exceed one
  `SRV_ASSERT_NOW(a_unit_range, out_valid, $signed(out_x) <= 16'sd16384 && $signed(out_x) >= -16'sd16384 && $signed(out_y) <= 16'sd16384 && $signed(out_y) >= -16'sd16384 && $signed(out_z) <= 16'sd16384 && $signed(out_z) >= -16'sd16384, "component beyond unit range")

  // a held result stays put
  `SRV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(total_internal), "stalled result changed")

endmodule

bind snell_refraction_vector srv_checker u_srv_checker (.*);

@@ tb/sv/snell_refraction_vector_test.sv @@
// self-checking bench for the vector refraction block: directed and random rays
// are checked against an in-bench fixed-point refraction predictor
// depends on: snell_refraction_vector and srv_pkg (through the dut only)
module snell_refraction_vector_test;

  localparam int LATENCY = 94;
  localparam int RANDOM_RAYS = 850;
  localparam logic [15:0] UNIT = 16'sh4000;
  localparam logic [15:0] NEG_UNIT = 16'shc000;

  typedef struct {
    logic signed [15:0] ix, iy, iz, nx, ny, nz;
    logic [15:0]        a, b;
  } ray_req_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    logic               tir;
  } ray_dir_t;

  typedef struct {
    ray_req_t req;
    bit       fixed;
    ray_dir_t dir;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] incident_x = '0, incident_y = '0, incident_z = '0;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic [15:0] ior_from = '0, ior_to = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_x, out_y, out_z;
  logic total_internal;

  ray_dir_t refracted_q[$];
  int errors = 0;
  bit driving_done = 1'b0;

  snell_refraction_vector dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_dir_t refract(ray_req_t r);
    ray_dir_t d;
    longint cosi, k, kmag;
    longint v[3], n[3], i[3];
    longint unsigned c, sq, s, lhs, rhs, rt, mx, sum, len, q;
    longint unsigned m[3];
    longint unsigned a, b;
    d = '{x: '0, y: '0, z: '0, tir: 1'b0};
    a = r.a;
    b = r.b;
    i[0] = r.ix; i[1] = r.iy; i[2] = r.iz;
    n[0] = r.nx; n[1] = r.ny; n[2] = r.nz;
    cosi = -(i[0] * n[0] + i[1] * n[1] + i[2] * n[2]);
    c = cosi < 0 ? -cosi : cosi;
    sq = (c * c) >> 28;
    s = sq >= (64'd1 << 28) ? 0 : (64'd1 << 28) - sq;
    lhs = a * a * s;
    rhs = (b * b) << 28;
    if (b == 0 || lhs > rhs) begin
      d.tir = 1'b1;
      return d;
    end
    rt = root_floor(rhs - lhs);
    k = longint'(a) * cosi - longint'(rt << 14);
    kmag = k < 0 ? -k : k;
    kmag = kmag >>> 14;
    k = k < 0 ? -kmag : kmag;
    mx = 0;
    for (int j = 0; j < 3; j++) begin
      v[j] = longint'(a) * i[j] * 16384 + k * n[j];
      m[j] = v[j] < 0 ? -v[j] : v[j];
      if (m[j] > mx) mx = m[j];
    end
    if (mx == 0) return d;
    while (mx >= (64'd1 << 30)) begin
      for (int j = 0; j < 3; j++) m[j] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int j = 0; j < 3; j++) m[j] <<= 1;
      mx <<= 1;
    end
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = root_floor(sum);
    for (int j = 0; j < 3; j++) begin
      q = ((m[j] << 14) + (len >> 1)) / len;
      q = v[j] < 0 ? (64'h10000 - q) : q;
      if (j == 0) d.x = q[15:0];
      else if (j == 1) d.y = q[15:0];
      else d.z = q[15:0];
    end
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic send_ray(ray_req_t r, ray_dir_t want);
    incident_x <= r.ix; incident_y <= r.iy; incident_z <= r.iz;
    normal_x <= r.nx; normal_y <= r.ny; normal_z <= r.nz;
    ior_from <= r.a; ior_to <= r.b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    refracted_q.push_back(want);
    @(negedge clk);
  endtask

  // random ray with unit-ish vectors, mostly well formed
  function automatic ray_req_t random_ray();
    ray_req_t r;
    int th;
    real ang, ph;
    if ($urandom_range(0, 9) == 0) begin
      r.ix = 16'($urandom); r.iy = 16'($urandom); r.iz = 16'($urandom);
      r.nx = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
      r.a = 16'($urandom); r.b = 16'($urandom);
      return r;
    end
    ang = $urandom_range(0, 6283) / 1000.0;
    ph = $urandom_range(0, 3141) / 1000.0;
    r.nx = 16'($rtoi(16384.0 * $sin(ph) * $cos(ang)));
    r.ny = 16'($rtoi(16384.0 * $sin(ph) * $sin(ang)));
    r.nz = 16'($rtoi(16384.0 * $cos(ph)));
    ang = $urandom_range(0, 6283) / 1000.0;
    ph = $urandom_range(0, 3141) / 1000.0;
    r.ix = 16'($rtoi(16384.0 * $sin(ph) * $cos(ang)));
    r.iy = 16'($rtoi(16384.0 * $sin(ph) * $sin(ang)));
    r.iz = 16'($rtoi(16384.0 * $cos(ph)));
    th = $urandom_range(0, 3);
    r.a = th == 0 ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(8192, 16384));
    r.b = th == 0 ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(8192, 16384));
    return r;
  endfunction

  initial begin
    ray_row_t rows[$];
    ray_dir_t zero_dir, tir_dir;
    ray_req_t r;
    int burst;
    int gap;
    zero_dir = '{x: '0, y: '0, z: '0, tir: 1'b0};
    tir_dir = '{x: '0, y: '0, z: '0, tir: 1'b1};
    // straight through, equal indices
    rows.push_back('{'{16'sh0, 16'sh0, NEG_UNIT, 16'sh0, 16'sh0, UNIT, 16'h2000, 16'h2000},
                     1, '{16'sh0, 16'sh0, NEG_UNIT, 1'b0}});
    // zero entered index
    rows.push_back('{'{16'sh0, 16'sh0, NEG_UNIT, 16'sh0, 16'sh0, UNIT, 16'h2000, 16'h0},
                     1, tir_dir});
    // grazing incidence from dense medium
    rows.push_back('{'{UNIT, 16'sh0, 16'sh0, 16'sh0, 16'sh0, UNIT, 16'h3000, 16'h2000},
                     1, tir_dir});
    // grazing limit, equal indices: sinT2 exactly one
    rows.push_back('{'{UNIT, 16'sh0, 16'sh0, 16'sh0, 16'sh0, UNIT, 16'h2000, 16'h2000},
                     0, zero_dir});
    // zero vectors give a zero refracted vector
    rows.push_back('{'{16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'h2000, 16'h2000},
                     1, zero_dir});
    // oversized vectors, clamped sine
    rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                       16'hffff, 16'h0001}, 0, zero_dir});
    rows.push_back('{'{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                       16'h0001, 16'hffff}, 0, zero_dir});
    rows.push_back('{'{16'shffff, 16'sh0001, 16'sh8000, 16'sh7fff, 16'shffff, 16'sh0001,
                       16'hffff, 16'hffff}, 0, zero_dir});
    rows.push_back('{'{16'sh2d41, 16'sh0, 16'shd2bf, 16'sh0, 16'sh0, UNIT, 16'h2000, 16'h2aaa},
                     0, zero_dir});
    rows.push_back('{'{16'sh2d41, 16'sh0, 16'shd2bf, 16'sh0, 16'sh0, UNIT, 16'h3000, 16'h2000},
                     0, zero_dir});
    rows.push_back('{'{16'sh0, 16'sh2d41, 16'sh2d41, 16'sh0, 16'sh0, NEG_UNIT, 16'h2000, 16'h3000},
                     0, zero_dir});
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[n]) begin
      ray_dir_t want;
      want = refract(rows[n].req);
      if (rows[n].fixed && want != rows[n].dir) begin
        $display("directed row %0d disagrees with its typed-in result", n);
        errors++;
      end
      send_ray(rows[n].req, rows[n].fixed ? rows[n].dir : want);
    end
    for (int n = 0; n < RANDOM_RAYS; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && n < RANDOM_RAYS; j++, n++) begin
        r = random_ray();
        send_ray(r, refract(r));
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    driving_done = 1'b1;
  end

  // receiver stalls in its own rhythm, with quiet stretches
  initial begin
    int mode;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 200)) begin
        @(negedge clk);
        out_stall <= mode == 0 ? 1'b0 : mode == 1 ? ($urandom_range(0, 3) == 0)
                     : ($urandom_range(0, 1) == 0);
      end
    end
  end

  always @(posedge clk) begin
    ray_dir_t want;
    if (!rst && out_valid && !out_stall) begin
      if (refracted_q.size() == 0) begin
        $display("unexpected request result %h %h %h %b", out_x, out_y, out_z, total_internal);
        errors++;
      end else begin
        want = refracted_q.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (total_internal !== want.tir)
          report_mismatch("total_internal", 16'(total_internal), 16'(want.tir));
      end
    end
  end

  initial begin
    wait (driving_done);
    while (refracted_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) $display("snell_refraction_vector regression: pass");
    else $display("snell_refraction_vector regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("snell_refraction_vector regression: fail");
    $finish;
  end

endmodule

@@ snell_refraction_vector.f @@
+incdir+rtl
rtl/srv_pkg.sv
rtl/srv_isqrt.sv
rtl/srv_front.sv
rtl/srv_vec.sv
rtl/srv_div3.sv
rtl/snell_refraction_vector.sv
rtl/srv_checker.sv
tb/sv/snell_refraction_vector_test.sv
